### hdl/min_jerk_quintic_coefficients_assert.svh
// Assertion macros used by the quintic coefficient top level.
`ifndef MIN_JERK_QUINTIC_COEFFICIENTS_ASSERT_SVH
`define MIN_JERK_QUINTIC_COEFFICIENTS_ASSERT_SVH
`ifndef SYNTHESIS
// Check the consequent in the same cycle as the antecedent.
`define MJQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mjq assertion failed");
// Check the consequent in the cycle after the antecedent.
`define MJQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mjq assertion failed");
`else
`define MJQ_ASSERT_NOW(label, ante, cons)
`define MJQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/mjq_pkg.sv
// Shared constants and types of the quintic coefficient pipeline.
`default_nettype none
package mjq_pkg;
  localparam int SW = 32;              // input state word
  localparam int TW = 24;              // duration word
  localparam int CW = 48;              // coefficient word
  localparam int NW = 88;              // signed numerator word
  localparam int MW = NW - 1;          // numerator magnitude word
  localparam int QB = CW;              // quotient bits per divider
  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT = QB + 2;
  localparam int PIPE_LAT = FRONT_LAT + DIV_LAT;

  typedef struct packed {
    logic [MW-1:0]   mag3;
    logic [MW-1:0]   mag4;
    logic [MW-1:0]   mag5;
    logic            neg3;
    logic            neg4;
    logic            neg5;
    logic [3*TW-1:0] d3;
    logic [4*TW-1:0] d4;
    logic [5*TW-1:0] d5;
  } front_out_t;

  typedef struct packed {
    logic [SW-1:0] pos;
    logic [SW-1:0] vel;
    logic [SW-1:0] acc;
    logic          tz;
  } side_t;
endpackage
`default_nettype wire

### hdl/mjq_front.sv
// Front pipeline: boundary residuals, numerators and powers of the duration.
`default_nettype none
module mjq_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [mjq_pkg::SW-1:0] start_pos,
  input  logic signed [mjq_pkg::SW-1:0] start_vel,
  input  logic signed [mjq_pkg::SW-1:0] start_acc,
  input  logic signed [mjq_pkg::SW-1:0] end_pos,
  input  logic signed [mjq_pkg::SW-1:0] end_vel,
  input  logic signed [mjq_pkg::SW-1:0] end_acc,
  input  logic        [mjq_pkg::TW-1:0] duration,
  output mjq_pkg::front_out_t           fo
);
  import mjq_pkg::*;

  // stage 1
  logic signed [SW:0]     dp1, dv1, da1;
  logic signed [SW-1:0]   acc1;
  logic signed [SW+TW:0]  vst1;
  logic [2*TW-1:0]        t2_1;
  logic [TW-1:0]          t1;
  // stage 2
  logic signed [SW:0]     dp2;
  logic signed [SW+TW:0]  vst2;
  logic signed [SW+TW:0]  ast2a, ast2b;
  logic signed [SW+TW+1:0] dat2a, dat2b, dvt2;
  logic [2*TW-1:0]        t3a, t3b, t4a, t4m, t4b;
  logic [TW-1:0]          t2;
  // stage 3
  logic signed [SW:0]     dp3;
  logic signed [SW+TW:0]  vst3;
  logic signed [SW+TW+1:0] dvt3;
  logic signed [NW-1:0]   ast2_3, ah3;
  logic [3*TW-1:0]        t3_3;
  logic [4*TW-1:0]        t4_3;
  logic [TW-1:0]          t3;
  // stage 4
  logic signed [NW-1:0]   h4, v4, ah4;
  logic [2*TW-1:0]        t5p [4];
  logic [3*TW-1:0]        t3_4;
  logic [4*TW-1:0]        t4_4;
  // stage 5
  logic signed [NW-1:0]   n3, n4, n5;
  logic [3*TW-1:0]        t3_5;
  logic [4*TW-1:0]        t4_5;
  logic [5*TW-1:0]        t5_5;

  always_ff @(posedge clk) begin
    if (en) begin
      // residual differences and first products
      dp1  <= {end_pos[SW-1], end_pos} - {start_pos[SW-1], start_pos};
      dv1  <= {end_vel[SW-1], end_vel} - {start_vel[SW-1], start_vel};
      da1  <= {end_acc[SW-1], end_acc} - {start_acc[SW-1], start_acc};
      acc1 <= start_acc;
      vst1 <= start_vel * $signed({1'b0, duration});
      t2_1 <= duration * duration;
      t1   <= duration;

      // partial products against the halves of T^2
      dp2   <= dp1;
      vst2  <= vst1;
      ast2a <= acc1 * $signed({1'b0, t2_1[TW-1:0]});
      ast2b <= acc1 * $signed({1'b0, t2_1[2*TW-1:TW]});
      dat2a <= da1 * $signed({1'b0, t2_1[TW-1:0]});
      dat2b <= da1 * $signed({1'b0, t2_1[2*TW-1:TW]});
      dvt2  <= dv1 * $signed({1'b0, t1});
      t3a   <= t2_1[TW-1:0] * t1;
      t3b   <= t2_1[2*TW-1:TW] * t1;
      t4a   <= t2_1[TW-1:0] * t2_1[TW-1:0];
      t4m   <= t2_1[TW-1:0] * t2_1[2*TW-1:TW];
      t4b   <= t2_1[2*TW-1:TW] * t2_1[2*TW-1:TW];
      t2    <= t1;

      // merge partial products
      dp3    <= dp2;
      vst3   <= vst2;
      dvt3   <= dvt2;
      ast2_3 <= NW'(ast2a) + (NW'(ast2b) <<< TW);
      ah3    <= NW'(dat2a) + (NW'(dat2b) <<< TW);
      t3_3   <= (3*TW)'(t3a) + ((3*TW)'(t3b) << TW);
      t4_3   <= (4*TW)'(t4a) + ((4*TW)'(t4m) << (TW + 1)) + ((4*TW)'(t4b) << (2*TW));
      t3     <= t2;

      // h, v in units of 2^-49
      h4  <= (NW'(dp3) <<< 33) - (NW'(vst3) <<< 17) - ast2_3;
      v4  <= (NW'(dvt3) <<< 17) - (ast2_3 <<< 1);
      ah4 <= ah3;
      for (int j = 0; j < 4; j++) begin
        t5p[j] <= t4_3[j*TW +: TW] * t3;
      end
      t3_4 <= t3_3;
      t4_4 <= t4_3;

      // numerators of the top three coefficients
      n3 <= (h4 <<< 3) + (h4 <<< 1) - (v4 <<< 2) + ah4;
      n4 <= (v4 <<< 3) - v4 - (h4 <<< 4) + h4 - (ah4 <<< 1);
      n5 <= (h4 <<< 2) + (h4 <<< 1) - (v4 <<< 1) - v4 + ah4;
      t5_5 <= (5*TW)'(t5p[0]) + ((5*TW)'(t5p[1]) << TW)
            + ((5*TW)'(t5p[2]) << (2*TW)) + ((5*TW)'(t5p[3]) << (3*TW));
      t3_5 <= t3_4;
      t4_5 <= t4_4;

      // sign and magnitude for the dividers
      fo.neg3 <= n3[NW-1];
      fo.neg4 <= n4[NW-1];
      fo.neg5 <= n5[NW-1];
      fo.mag3 <= MW'(n3[NW-1] ? -n3 : n3);
      fo.mag4 <= MW'(n4[NW-1] ? -n4 : n4);
      fo.mag5 <= MW'(n5[NW-1] ? -n5 : n5);
      fo.d3   <= t3_5;
      fo.d4   <= t4_5;
      fo.d5   <= t5_5;
    end
  end
endmodule
`default_nettype wire

### hdl/mjq_div.sv
// Pipelined restoring divider: rounded, saturated quotient mag * 2^SHIFT / d.
`default_nettype none
module mjq_div #(
  parameter int SHIFT = 23,
  parameter int DW    = 72
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [mjq_pkg::MW-1:0]   mag,
  input  logic                     neg,
  input  logic [DW-1:0]            d,
  output logic [mjq_pkg::CW-1:0]   coef,
  output logic                     sat
);
  import mjq_pkg::*;

  localparam int XW = MW + SHIFT + 2;
  localparam int YW = DW + 1;
  localparam int RW = (XW > YW + QB) ? XW : YW + QB;

  logic [RW-1:0] x;
  logic [RW-1:0] r   [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic [YW-1:0] y   [QB+1];
  logic          ng  [QB+1];
  logic          big [QB+1];
  logic [QB-1:0] lim, qs;
  logic          over;

  // round half up: (2*mag*2^SHIFT + d) / (2d)
  assign x = (RW'(mag) << (SHIFT + 1)) + RW'(d);

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= x;
      q[0]   <= '0;
      y[0]   <= {d, 1'b0};
      ng[0]  <= neg;
      big[0] <= x >= (RW'({d, 1'b0}) << QB);
      // one quotient bit per stage, most significant first
      for (int i = 0; i < QB; i++) begin
        if (r[i] >= (RW'(y[i]) << (QB - 1 - i))) begin
          r[i+1] <= r[i] - (RW'(y[i]) << (QB - 1 - i));
          q[i+1] <= q[i] | (QB'(1) << (QB - 1 - i));
        end else begin
          r[i+1] <= r[i];
          q[i+1] <= q[i];
        end
        y[i+1]   <= y[i];
        ng[i+1]  <= ng[i];
        big[i+1] <= big[i];
      end
    end
  end

  assign lim  = ng[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
  assign over = big[QB] || (q[QB] > lim);
  assign qs   = over ? lim : q[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      sat  <= over;
      coef <= CW'(ng[QB] ? -qs : qs);
    end
  end
endmodule
`default_nettype wire

### hdl/min_jerk_quintic_coefficients.sv
// Top level of the minimum-jerk quintic coefficient pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item: start and end states in
//   signed Q16.16 and the duration T in unsigned Q8.16. The output channel
//   (out_valid / out_stall) returns one item per input: six Q24.24
//   coefficients and a fault flag (T zero, or coef_3..coef_5 saturated).
//   Throughput is one item per cycle while out_stall does not hold the pipeline.
//   From acceptance to out_valid an item passes six front stages (residuals, T
//   powers, numerators), 50 divider stages (one quotient bit per stage over 48
//   bits plus setup and saturation), and the output register.
//   The whole pipeline advances as one; while a result waits under out_stall,
//   every stage holds and in_stall is raised, so nothing is lost or repeated.
//   Reset clears all valid bits and the output valid; payload is not reset.
//   With T zero, coef_3..coef_5 read as zero and fault is set.
`default_nettype none
`include "min_jerk_quintic_coefficients_assert.svh"
module min_jerk_quintic_coefficients (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [mjq_pkg::SW-1:0] start_pos,
  input  logic signed [mjq_pkg::SW-1:0] start_vel,
  input  logic signed [mjq_pkg::SW-1:0] start_acc,
  input  logic signed [mjq_pkg::SW-1:0] end_pos,
  input  logic signed [mjq_pkg::SW-1:0] end_vel,
  input  logic signed [mjq_pkg::SW-1:0] end_acc,
  input  logic        [mjq_pkg::TW-1:0] duration,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [mjq_pkg::CW-1:0] coef_0,
  output logic signed [mjq_pkg::CW-1:0] coef_1,
  output logic signed [mjq_pkg::CW-1:0] coef_2,
  output logic signed [mjq_pkg::CW-1:0] coef_3,
  output logic signed [mjq_pkg::CW-1:0] coef_4,
  output logic signed [mjq_pkg::CW-1:0] coef_5,
  output logic                          fault
);
  import mjq_pkg::*;

  logic        en;
  front_out_t  fo;
  logic        vld    [PIPE_LAT];
  side_t       side_q [PIPE_LAT];
  logic [CW-1:0] q3, q4, q5;
  logic        sat3, sat4, sat5;
  side_t       so;

  // advance whenever the output register is free or being taken
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  mjq_front u_front (
    .clk, .en,
    .start_pos, .start_vel, .start_acc,
    .end_pos, .end_vel, .end_acc,
    .duration,
    .fo
  );

  mjq_div #(.SHIFT(23), .DW(3*TW)) u_div3 (
    .clk, .en, .mag(fo.mag3), .neg(fo.neg3), .d(fo.d3), .coef(q3), .sat(sat3)
  );
  mjq_div #(.SHIFT(39), .DW(4*TW)) u_div4 (
    .clk, .en, .mag(fo.mag4), .neg(fo.neg4), .d(fo.d4), .coef(q4), .sat(sat4)
  );
  mjq_div #(.SHIFT(55), .DW(5*TW)) u_div5 (
    .clk, .en, .mag(fo.mag5), .neg(fo.neg5), .d(fo.d5), .coef(q5), .sat(sat5)
  );

  // valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // carry the start state for the low coefficients and the zero-T flag
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= '{pos: start_pos, vel: start_vel, acc: start_acc, tz: duration == '0};
      for (int i = 1; i < PIPE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign so = side_q[PIPE_LAT-1];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_0 <= {{(CW-SW-8){so.pos[SW-1]}}, so.pos, 8'b0};
      coef_1 <= {{(CW-SW-8){so.vel[SW-1]}}, so.vel, 8'b0};
      coef_2 <= {{(CW-SW-7){so.acc[SW-1]}}, so.acc, 7'b0};
      coef_3 <= so.tz ? '0 : q3;
      coef_4 <= so.tz ? '0 : q4;
      coef_5 <= so.tz ? '0 : q5;
      fault  <= so.tz || sat3 || sat4 || sat5;
    end
  end

  `MJQ_ASSERT_NEXT(a_capture, en && in_valid, vld[0])
  `MJQ_ASSERT_NEXT(a_tz_result, en && vld[PIPE_LAT-1] && so.tz,
                   out_valid && fault && coef_3 == '0 && coef_4 == '0 && coef_5 == '0)
  `MJQ_ASSERT_NEXT(a_clean_result, en && vld[PIPE_LAT-1] && !so.tz && !sat3 && !sat4 && !sat5,
                   out_valid && !fault)
endmodule
`default_nettype wire

### test/tb_min_jerk_quintic_coefficients.sv
// Self-checking testbench for the minimum-jerk quintic coefficient pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_min_jerk_quintic_coefficients;
  import mjq_pkg::*;

  // One boundary problem: start state, end state and duration.
  typedef struct {
    logic signed [SW-1:0] sp;
    logic signed [SW-1:0] sv;
    logic signed [SW-1:0] sa;
    logic signed [SW-1:0] ep;
    logic signed [SW-1:0] ev;
    logic signed [SW-1:0] ea;
    logic [TW-1:0]        dur;
  } problem_t;

  // The six coefficients and the fault flag of one problem.
  typedef struct {
    logic [CW-1:0] c [6];
    logic          flt;
  } coefs_t;

  // One row of the directed table; the answer is typed in where it is obvious.
  typedef struct {
    problem_t p;
    bit       known;
    coefs_t   ans;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [SW-1:0] start_pos, start_vel, start_acc, end_pos, end_vel, end_acc;
  logic [TW-1:0] duration;
  logic out_valid;
  logic out_stall;
  logic signed [CW-1:0] coef_0, coef_1, coef_2, coef_3, coef_4, coef_5;
  logic fault;

  coefs_t pending_coefs[$];
  row_t   rows[$];
  int     mismatches = 0;
  bit     stimulus_done = 0;

  min_jerk_quintic_coefficients DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_pos(start_pos), .start_vel(start_vel), .start_acc(start_acc),
    .end_pos(end_pos), .end_vel(end_vel), .end_acc(end_acc),
    .duration(duration),
    .out_valid(out_valid), .out_stall(out_stall),
    .coef_0(coef_0), .coef_1(coef_1), .coef_2(coef_2),
    .coef_3(coef_3), .coef_4(coef_4), .coef_5(coef_5),
    .fault(fault)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round |n| * 2^sh / t^k to nearest, ties away from zero, then clamp to 48 bits.
  function automatic logic [CW-1:0] rounded_quotient(input logic signed [191:0] n,
                                                     input int sh, input int k,
                                                     input logic [191:0] t,
                                                     inout logic sat);
    logic [191:0] mag, d, x, lim;
    logic neg;
    neg = n[191];
    mag = neg ? -n : n;
    d = 192'd1;
    for (int i = 0; i < k; i++) d = d * t;
    x = ((mag << (sh + 1)) + d) / d;
    x = x >> 1;
    lim = neg ? (192'd1 << 47) : ((192'd1 << 47) - 1);
    if (x > lim) begin
      x = lim;
      sat = 1'b1;
    end
    mag = neg ? -x : x;
    return mag[CW-1:0];
  endfunction

  // Work out the quintic coefficients of one problem.
  function automatic coefs_t quintic_coefs(input problem_t p);
    logic signed [191:0] ps, vs, as_, pe, ve, ae, t, ast2, h, v, ah, n3, n4, n5;
    logic sat;
    coefs_t r;
    ps = p.sp; vs = p.sv; as_ = p.sa;
    pe = p.ep; ve = p.ev; ae = p.ea;
    t = {168'd0, p.dur};
    sat = 1'b0;
    r.c[0] = ps[CW-1:0] << 8;
    r.c[1] = vs[CW-1:0] << 8;
    r.c[2] = as_[CW-1:0] << 7;
    if (p.dur == '0) begin
      r.c[3] = '0; r.c[4] = '0; r.c[5] = '0;
      r.flt = 1'b1;
      return r;
    end
    // Residuals h, v and a/2, all scaled by 2^49.
    ast2 = as_ * t * t;
    h = ((pe - ps) <<< 33) - ((vs * t) <<< 17) - ast2;
    v = (((ve - vs) * t) <<< 17) - (ast2 <<< 1);
    ah = (ae - as_) * t * t;
    n3 = 10 * h - 4 * v + ah;
    n4 = -15 * h + 7 * v - 2 * ah;
    n5 = 6 * h - 3 * v + ah;
    r.c[3] = rounded_quotient(n3, 23, 3, t, sat);
    r.c[4] = rounded_quotient(n4, 39, 4, t, sat);
    r.c[5] = rounded_quotient(n5, 55, 5, t, sat);
    r.flt = sat;
    return r;
  endfunction

  function automatic problem_t make_problem(input logic [SW-1:0] sp, sv, sa, ep, ev, ea,
                                            input logic [TW-1:0] dur);
    problem_t p;
    p.sp = sp; p.sv = sv; p.sa = sa; p.ep = ep; p.ev = ev; p.ea = ea; p.dur = dur;
    return p;
  endfunction

  task automatic add_row(input problem_t p, input bit known, input coefs_t ans);
    row_t r;
    r.p = p; r.known = known; r.ans = ans;
    rows.insert(rows.size(), r);
  endtask

  // Drive one item, record its answer, and hold it until it is taken.
  task automatic send_item(input problem_t p, input bit known, input coefs_t ans);
    in_valid  <= 1'b1;
    start_pos <= p.sp; start_vel <= p.sv; start_acc <= p.sa;
    end_pos   <= p.ep; end_vel   <= p.ev; end_acc   <= p.ea;
    duration  <= p.dur;
    pending_coefs.insert(pending_coefs.size(), known ? ans : quintic_coefs(p));
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid for a random number of cycles.
  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic problem_t random_problem();
    problem_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p = make_problem($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     TW'($urandom_range(0, 24'hFFFFFF)));
    if (kind < 6) begin
      // Realistic maneuver: moderate states, T between a fraction and many seconds.
      p.sp = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
      p.sv = $signed($urandom_range(0, 32'h003FFFFF)) - 32'sh001FFFFF;
      p.sa = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF;
      p.ep = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
      p.ev = $signed($urandom_range(0, 32'h003FFFFF)) - 32'sh001FFFFF;
      p.ea = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF;
      p.dur = TW'($urandom_range(24'h002000, 24'h1FFFFF));
    end else if (kind == 6) begin
      p.dur = TW'($urandom_range(1, 24'h0003FF));     // tiny T: mostly saturates
    end else if (kind == 7) begin
      p.dur = TW'($urandom_range(24'hF00000, 24'hFFFFFF));
    end else if (kind == 8 && $urandom_range(0, 3) == 0) begin
      p.dur = '0;
    end
    return p;
  endfunction

  // Output check: compare each taken result with the oldest answer.
  always @(posedge clk) begin
    coefs_t want;
    logic [CW-1:0] got [6];
    if (!rst && out_valid && !out_stall) begin
      got[0] = coef_0; got[1] = coef_1; got[2] = coef_2;
      got[3] = coef_3; got[4] = coef_4; got[5] = coef_5;
      if (pending_coefs.size() == 0) begin
        $display("%0t: unexpected result, coef_0 %h fault %b", $time, coef_0, fault);
        mismatches++;
      end else begin
        want = pending_coefs.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want.c[i]) begin
            $display("%0t: coef_%0d expected %h actual %h", $time, i, want.c[i], got[i]);
            mismatches++;
          end
        if (fault !== want.flt) begin
          $display("%0t: fault expected %b actual %b", $time, want.flt, fault);
          mismatches++;
        end
      end
    end
  end

  // Receiver back-pressure: switch between free running, light, heavy and periodic stalls.
  int stall_cycle = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 150 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_cycle % 7 < 2);
      endcase
    end
  end

  initial begin
    coefs_t ans, none;
    problem_t p;
    int burst;
    none = '{c: '{default: '0}, flt: 1'b0};
    rst = 1'b1;
    in_valid = 1'b0;
    start_pos = '0; start_vel = '0; start_acc = '0;
    end_pos = '0; end_vel = '0; end_acc = '0;
    duration = '0;

    // Directed rows. All-zero problem with unit step of T: everything zero.
    ans = none;
    add_row(make_problem(0, 0, 0, 0, 0, 0, 1), 1, ans);
    // Zero duration: high coefficients zero, fault up, low ones still formed.
    ans = none; ans.flt = 1'b1;
    add_row(make_problem(0, 0, 0, 0, 0, 0, 0), 1, ans);
    ans.c[0] = 48'h007FFFFFFF00; ans.c[1] = 48'hFF8000000000; ans.c[2] = 48'hFFC000000000;
    add_row(make_problem(32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                        32'h12345678, 32'h80000000, 32'h7FFFFFFF, 0), 1, ans);
    ans.c[0] = 48'hFF8000000000; ans.c[1] = 48'h007FFFFFFF00; ans.c[2] = 48'h003FFFFFFF80;
    add_row(make_problem(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0), 1, ans);
    // Extremes against the predictor: saturation both ways, longest T, rest to rest.
    add_row(make_problem(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 1), 0, none);
    add_row(make_problem(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 1), 0, none);
    add_row(make_problem(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF), 0, none);
    add_row(make_problem(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'h80000000, 32'h80000000, 24'hFFFFFF), 0, none);
    add_row(make_problem(0, 0, 0, 32'h00010000, 0, 0, 24'h010000), 0, none);
    add_row(make_problem(0, 0, 0, 32'h000A0000, 0, 0, 24'h050000), 0, none);
    add_row(make_problem(0, 32'h00010000, 0, 32'h00010000, 32'h00010000, 0,
                        24'h010000), 0, none);
    add_row(make_problem(0, 0, 32'h00020000, 32'h00010000, 32'h00020000,
                        32'h00020000, 24'h010000), 0, none);
    add_row(make_problem(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                        32'h00000001, 32'h00000001, 32'h00000001, 24'h000001), 0, none);
    add_row(make_problem(0, 0, 0, 32'h00000001, 0, 0, 24'h800000), 0, none);
    add_row(make_problem(0, 0, 0, 32'hFFFFFFFF, 0, 0, 24'h000003), 0, none);
    add_row(make_problem(32'h00500000, 32'hFFF00000, 32'h00008000,
                        32'h00100000, 32'h00040000, 32'hFFFF0000, 24'h028000), 0, none);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table back to back.
    foreach (rows[i]) send_item(rows[i].p, rows[i].known, rows[i].ans);

    // Random part in bursts with gaps; pause once for a full drain midway.
    for (int n = 0; n < 800; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        p = random_problem();
        send_item(p, 0, none);
        n++;
        if (n == 400) begin
          in_valid <= 1'b0;
          wait (pending_coefs.size() == 0);
          @(posedge clk);
        end
      end
      sender_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    wait (pending_coefs.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (mismatches == 0 && pending_coefs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/mjq_pkg.sv
hdl/mjq_front.sv
hdl/mjq_div.sv
hdl/min_jerk_quintic_coefficients.sv
test/tb_min_jerk_quintic_coefficients.sv
